// ===== src/assert_macros.svh =====
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// check a property on every clock edge outside reset
`define ASSERT_PROP(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("assertion failed");

// check that a condition holds in the cycle after its trigger
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ===== src/scif_pkg.sv =====
`timescale 1ns / 1ps

package scif_pkg;

    typedef struct packed {
        logic [7:0] char_byte;
        logic       is_end;
    } item_t;

    typedef enum logic [1:0] {
        CLASS_NONE  = 2'd0,
        CLASS_INT   = 2'd1,
        CLASS_FLOAT = 2'd2
    } scalar_class_t;

    typedef enum logic [8:0] {
        IP_START  = 9'b000000001,
        IP_ZERO   = 9'b000000010,
        IP_SIGNED = 9'b000000100,
        IP_DEC    = 9'b000001000,
        IP_OCT_E  = 9'b000010000,
        IP_OCT    = 9'b000100000,
        IP_HEX_E  = 9'b001000000,
        IP_HEX    = 9'b010000000,
        IP_DEAD   = 9'b100000000
    } int_phase_t;

    typedef enum logic [8:0] {
        FP_START    = 9'b000000001,
        FP_SIGNED   = 9'b000000010,
        FP_INT      = 9'b000000100,
        FP_DOT      = 9'b000001000,
        FP_FRAC     = 9'b000010000,
        FP_EXP_E    = 9'b000100000,
        FP_EXP_SIGN = 9'b001000000,
        FP_EXP_DIG  = 9'b010000000,
        FP_DEAD     = 9'b100000000
    } float_phase_t;

    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_SEVEN = 8'h37;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_LO_O  = 8'h6F;
    localparam logic [7:0] CH_LO_X  = 8'h78;
    localparam logic [7:0] CH_LO_E  = 8'h65;
    localparam logic [7:0] CH_UP_E  = 8'h45;
    localparam logic [7:0] CH_LO_A  = 8'h61;
    localparam logic [7:0] CH_LO_F  = 8'h66;
    localparam logic [7:0] CH_UP_A  = 8'h41;
    localparam logic [7:0] CH_UP_F  = 8'h46;

    localparam int WORD_LEN   = 4;
    localparam int WORD_COUNT = 6;

    localparam logic [2:0] WORD_POS_MAX = 3'd5;
    localparam logic [2:0] WORD_POS_LEN = 3'd4;

    localparam logic [WORD_COUNT-1:0] ALL_WORDS = 6'b111111;
    localparam logic [WORD_COUNT-1:0] NAN_MASK  = 6'b000111;

    // .nan .NaN .NAN .inf .Inf .INF
    localparam logic [7:0] WORD_TABLE [WORD_COUNT][WORD_LEN] = '{
        '{8'h2E, 8'h6E, 8'h61, 8'h6E},
        '{8'h2E, 8'h4E, 8'h61, 8'h4E},
        '{8'h2E, 8'h4E, 8'h41, 8'h4E},
        '{8'h2E, 8'h69, 8'h6E, 8'h66},
        '{8'h2E, 8'h49, 8'h6E, 8'h66},
        '{8'h2E, 8'h49, 8'h4E, 8'h46}
    };

endpackage

// ===== src/scif_in_stage.sv =====
`timescale 1ns / 1ps

module scif_in_stage
    import scif_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // char_byte
    input  logic       s_tlast,   // is_end
    input  logic       advance,
    output logic       item_valid,
    output item_t      item
);

    logic  valid_reg;
    logic  valid_next;
    item_t item_reg;

    assign s_tready   = !valid_reg || advance;
    assign item_valid = valid_reg;
    assign item       = item_reg;

    always_comb
    begin
        valid_next = valid_reg;
        if (s_tready)
        begin
            valid_next = s_tvalid;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
        begin
            item_reg.char_byte <= s_tdata;
            item_reg.is_end    <= s_tlast;
        end
    end

endmodule

// ===== src/scif_core.sv =====
`timescale 1ns / 1ps

`include "assert_macros.svh"

module scif_core
    import scif_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          step,
    input  item_t         item,
    output scalar_class_t cls
);

    int_phase_t              int_phase_reg;
    int_phase_t              int_phase_next;
    float_phase_t            float_phase_reg;
    float_phase_t            float_phase_next;
    logic [2:0]              word_pos_reg;
    logic [2:0]              word_pos_next;
    logic [WORD_COUNT-1:0]   word_cand_reg;
    logic [WORD_COUNT-1:0]   word_cand_next;
    logic                    sign_seen_reg;
    logic                    sign_seen_next;

    logic [7:0]              c;
    logic                    c_dec;
    logic                    c_oct;
    logic                    c_hex;
    logic                    c_sign;
    logic [WORD_COUNT-1:0]   keep;

    assign c      = item.char_byte;
    assign c_dec  = c inside {[CH_ZERO:CH_NINE]};
    assign c_oct  = c inside {[CH_ZERO:CH_SEVEN]};
    assign c_hex  = c inside {[CH_ZERO:CH_NINE], [CH_LO_A:CH_LO_F], [CH_UP_A:CH_UP_F]};
    assign c_sign = (c == CH_PLUS) || (c == CH_MINUS);

    always_comb
    begin
        case (int_phase_reg)
            IP_START:
            begin
                if (c == CH_ZERO)
                    int_phase_next = IP_ZERO;
                else if (c_sign)
                    int_phase_next = IP_SIGNED;
                else
                    int_phase_next = c_dec ? IP_DEC : IP_DEAD;
            end
            IP_ZERO:
            begin
                if (c == CH_LO_O)
                    int_phase_next = IP_OCT_E;
                else if (c == CH_LO_X)
                    int_phase_next = IP_HEX_E;
                else
                    int_phase_next = c_dec ? IP_DEC : IP_DEAD;
            end
            IP_SIGNED, IP_DEC: int_phase_next = c_dec ? IP_DEC : IP_DEAD;
            IP_OCT_E, IP_OCT:  int_phase_next = c_oct ? IP_OCT : IP_DEAD;
            IP_HEX_E, IP_HEX:  int_phase_next = c_hex ? IP_HEX : IP_DEAD;
            default:           int_phase_next = IP_DEAD;
        endcase
    end

    always_comb
    begin
        case (float_phase_reg)
            FP_START:
            begin
                if (c_sign)
                    float_phase_next = FP_SIGNED;
                else if (c_dec)
                    float_phase_next = FP_INT;
                else
                    float_phase_next = (c == CH_DOT) ? FP_DOT : FP_DEAD;
            end
            FP_SIGNED:
            begin
                if (c_dec)
                    float_phase_next = FP_INT;
                else
                    float_phase_next = (c == CH_DOT) ? FP_DOT : FP_DEAD;
            end
            FP_INT:
            begin
                if (c_dec)
                    float_phase_next = FP_INT;
                else
                    float_phase_next = (c == CH_DOT) ? FP_FRAC : FP_DEAD;
            end
            FP_DOT: float_phase_next = c_dec ? FP_FRAC : FP_DEAD;
            FP_FRAC:
            begin
                if (c_dec)
                    float_phase_next = FP_FRAC;
                else if ((c == CH_LO_E) || (c == CH_UP_E))
                    float_phase_next = FP_EXP_E;
                else
                    float_phase_next = FP_DEAD;
            end
            FP_EXP_E:
            begin
                if (c_sign)
                    float_phase_next = FP_EXP_SIGN;
                else
                    float_phase_next = c_dec ? FP_EXP_DIG : FP_DEAD;
            end
            FP_EXP_SIGN, FP_EXP_DIG: float_phase_next = c_dec ? FP_EXP_DIG : FP_DEAD;
            default:                 float_phase_next = FP_DEAD;
        endcase
    end

    always_comb
    begin
        for (int k = 0; k < WORD_COUNT; k++)
        begin
            keep[k] = (word_pos_reg < WORD_POS_LEN) &&
                      (WORD_TABLE[k][word_pos_reg[1:0]] == c);
        end
    end

    always_comb
    begin
        sign_seen_next = sign_seen_reg;
        word_cand_next = word_cand_reg;
        word_pos_next  = word_pos_reg;
        if ((float_phase_reg == FP_START) && c_sign)
        begin
            sign_seen_next = 1'b1;
            word_cand_next = word_cand_reg & ~NAN_MASK;
        end
        else
        begin
            word_cand_next = word_cand_reg & keep;
            if (word_pos_reg < WORD_POS_MAX)
            begin
                word_pos_next = word_pos_reg + 3'd1;
            end
        end
    end

    always_comb
    begin
        if ((int_phase_reg == IP_ZERO) || (int_phase_reg == IP_DEC) ||
            (int_phase_reg == IP_OCT) || (int_phase_reg == IP_HEX))
            cls = CLASS_INT;
        else if ((float_phase_reg == FP_FRAC) || (float_phase_reg == FP_EXP_DIG) ||
                 ((word_pos_reg == WORD_POS_LEN) && (word_cand_reg != '0)))
            cls = CLASS_FLOAT;
        else
            cls = CLASS_NONE;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            int_phase_reg   <= IP_START;
            float_phase_reg <= FP_START;
            word_pos_reg    <= '0;
            word_cand_reg   <= ALL_WORDS;
            sign_seen_reg   <= 1'b0;
        end
        else if (step)
        begin
            if (item.is_end)
            begin
                int_phase_reg   <= IP_START;
                float_phase_reg <= FP_START;
                word_pos_reg    <= '0;
                word_cand_reg   <= ALL_WORDS;
                sign_seen_reg   <= 1'b0;
            end
            else
            begin
                int_phase_reg   <= int_phase_next;
                float_phase_reg <= float_phase_next;
                word_pos_reg    <= word_pos_next;
                word_cand_reg   <= word_cand_next;
                sign_seen_reg   <= sign_seen_next;
            end
        end
    end

    `ASSERT_NEXT(a_end_restarts, clk, rst_n, step && item.is_end,
        (int_phase_reg == IP_START) && (float_phase_reg == FP_START) && (word_pos_reg == 3'd0))
    `ASSERT_PROP(a_signed_no_nan, clk, rst_n,
        !sign_seen_reg || ((word_cand_reg & NAN_MASK) == '0))
    `ASSERT_NEXT(a_int_dead_sticks, clk, rst_n,
        step && !item.is_end && (int_phase_reg == IP_DEAD), int_phase_reg == IP_DEAD)

endmodule

// ===== src/scif_out_reg.sv =====
`timescale 1ns / 1ps

module scif_out_reg
    import scif_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          load,
    input  scalar_class_t cls,
    output logic          free,
    output logic          m_tvalid,
    input  logic          m_tready,
    output logic [7:0]    m_tdata    // scalar_class, zero padding
);

    logic          valid_reg;
    logic          valid_next;
    scalar_class_t class_reg;

    assign free     = !valid_reg || m_tready;
    assign m_tvalid = valid_reg;
    assign m_tdata  = {6'b0, class_reg};

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
            valid_next = 1'b1;
        else if (m_tready)
            valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            class_reg <= cls;
        end
    end

endmodule

// ===== src/scalar_int_float_classifier.sv =====
`timescale 1ns / 1ps

// Classifies a scalar streamed one character per transfer on the slave side,
// closed by a transfer with s_tlast high (its data is ignored). For each
// closing transfer one result transfer follows on the master side: 0 neither,
// 1 integer, 2 float, integer taking precedence. Character transfers give no
// result. One transfer is accepted every cycle unless the slave side stalls;
// m_tvalid rises once the closing transfer has passed the input register, the
// combinational class logic and the result register. The slave side stalls only
// while a closing transfer waits for a result that has not been taken.

module scalar_int_float_classifier
    import scif_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // char_byte
    input  logic       s_tlast,   // is_end
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata    // scalar_class, zero padding
);

    logic          item_valid;
    item_t         item;
    logic          advance;
    logic          out_free;
    scalar_class_t cls;

    assign advance = item_valid && (!item.is_end || out_free);

    scif_in_stage u_in_stage (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tlast    (s_tlast),
        .advance    (advance),
        .item_valid (item_valid),
        .item       (item)
    );

    scif_core u_core (
        .clk   (clk),
        .rst_n (rst_n),
        .step  (advance),
        .item  (item),
        .cls   (cls)
    );

    scif_out_reg u_out_reg (
        .clk      (clk),
        .rst_n    (rst_n),
        .load     (advance && item.is_end),
        .cls      (cls),
        .free     (out_free),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

endmodule

// ===== test/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;
    import scif_pkg::*;

    localparam int ITEM_TARGET  = 750;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int DRAIN_CYCLES = 8;

    class class_scoreboard;
        int_phase_t     ip;
        float_phase_t   fp;
        logic [2:0]     word_pos;
        logic [5:0]     word_cands;
        bit             sign_first;
        scalar_class_t  pending_classes[$];
        int             errors;

        function new();
            errors = 0;
            clear_scalar();
        endfunction

        function void clear_scalar();
            ip         = IP_START;
            fp         = FP_START;
            word_pos   = 3'd0;
            word_cands = ALL_WORDS;
            sign_first = 1'b0;
        endfunction

        function bit is_dec(logic [7:0] c);
            return c >= CH_ZERO && c <= CH_NINE;
        endfunction

        function bit is_oct(logic [7:0] c);
            return c >= CH_ZERO && c <= CH_SEVEN;
        endfunction

        function bit is_hex(logic [7:0] c);
            return is_dec(c) || (c >= CH_LO_A && c <= CH_LO_F) || (c >= CH_UP_A && c <= CH_UP_F);
        endfunction

        function bit is_sign(logic [7:0] c);
            return c == CH_PLUS || c == CH_MINUS;
        endfunction

        function void step_words(logic [7:0] c, bit first);
            logic [5:0] keep;
            keep = '0;
            if (first && is_sign(c))
            begin
                sign_first = 1'b1;
                word_cands = word_cands & ~NAN_MASK;
                return;
            end
            if (word_pos < WORD_POS_LEN)
            begin
                for (int k = 0; k < WORD_COUNT; k++)
                begin
                    if (WORD_TABLE[k][int'(word_pos)] == c)
                        keep[k] = 1'b1;
                end
            end
            word_cands = word_cands & keep;
            if (word_pos < WORD_POS_MAX)
                word_pos = word_pos + 3'd1;
        endfunction

        function void step_int(logic [7:0] c);
            case (ip)
                IP_START:
                    if (c == CH_ZERO) ip = IP_ZERO;
                    else if (is_sign(c)) ip = IP_SIGNED;
                    else ip = is_dec(c) ? IP_DEC : IP_DEAD;
                IP_ZERO:
                    if (c == CH_LO_O) ip = IP_OCT_E;
                    else if (c == CH_LO_X) ip = IP_HEX_E;
                    else ip = is_dec(c) ? IP_DEC : IP_DEAD;
                IP_SIGNED, IP_DEC:
                    ip = is_dec(c) ? IP_DEC : IP_DEAD;
                IP_OCT_E, IP_OCT:
                    ip = is_oct(c) ? IP_OCT : IP_DEAD;
                IP_HEX_E, IP_HEX:
                    ip = is_hex(c) ? IP_HEX : IP_DEAD;
                default:
                    ip = IP_DEAD;
            endcase
        endfunction

        function void step_float(logic [7:0] c);
            case (fp)
                FP_START, FP_SIGNED:
                    if (fp == FP_START && is_sign(c)) fp = FP_SIGNED;
                    else if (is_dec(c)) fp = FP_INT;
                    else fp = (c == CH_DOT) ? FP_DOT : FP_DEAD;
                FP_INT:
                    if (is_dec(c)) fp = FP_INT;
                    else fp = (c == CH_DOT) ? FP_FRAC : FP_DEAD;
                FP_DOT:
                    fp = is_dec(c) ? FP_FRAC : FP_DEAD;
                FP_FRAC:
                    if (is_dec(c)) fp = FP_FRAC;
                    else fp = (c == CH_LO_E || c == CH_UP_E) ? FP_EXP_E : FP_DEAD;
                FP_EXP_E, FP_EXP_SIGN, FP_EXP_DIG:
                    if (fp == FP_EXP_E && is_sign(c)) fp = FP_EXP_SIGN;
                    else fp = is_dec(c) ? FP_EXP_DIG : FP_DEAD;
                default:
                    fp = FP_DEAD;
            endcase
        endfunction

        function void note_item(logic [7:0] c, bit last);
            scalar_class_t cls;
            if (!last)
            begin
                step_words(c, fp == FP_START);
                step_int(c);
                step_float(c);
                return;
            end
            if (ip == IP_ZERO || ip == IP_DEC || ip == IP_OCT || ip == IP_HEX)
                cls = CLASS_INT;
            else if (fp == FP_FRAC || fp == FP_EXP_DIG ||
                     (word_pos == WORD_POS_LEN && word_cands != '0))
                cls = CLASS_FLOAT;
            else
                cls = CLASS_NONE;
            pending_classes.push_back(cls);
            clear_scalar();
        endfunction

        task report(string msg);
            $display("MISMATCH: %s", msg);
            errors++;
        endtask

        task check_class(logic [7:0] data);
            scalar_class_t want;
            if (pending_classes.size() == 0)
            begin
                report($sformatf("class %0d with no scalar pending", data[1:0]));
                return;
            end
            want = pending_classes.pop_front();
            if (data[1:0] !== want)
                report($sformatf("scalar_class %0d, want %0d", data[1:0], want));
        endtask

        task check_leftover();
            if (pending_classes.size() != 0)
                report($sformatf("%0d classes never arrived", pending_classes.size()));
        endtask
    endclass

    logic       clk;
    logic       rst_n;
    logic       s_tvalid;
    logic       s_tready;
    logic [7:0] s_tdata;
    logic       s_tlast;
    logic       m_tvalid;
    logic       m_tready;
    logic [7:0] m_tdata;

    class_scoreboard sb;
    int items_sent;
    int burst_left;
    int cycles;
    int ready_mode;
    int ready_hold;

    scalar_int_float_classifier u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always #10 clk = ~clk;

    always @(posedge clk)
    begin
        cycles++;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("== FAIL ==");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
            sb.check_class(m_tdata);
    end

    always @(negedge clk)
    begin
        if (ready_hold == 0)
        begin
            ready_mode = $urandom_range(0, 3);
            ready_hold = $urandom_range(20, 80);
        end
        ready_hold--;
        case (ready_mode)
            0: m_tready <= 1'b1;
            1: m_tready <= 1'($urandom_range(0, 1));
            2: m_tready <= ($urandom_range(0, 3) != 0);
            default: m_tready <= ($urandom_range(0, 7) == 0);
        endcase
    end

    // call at a falling edge; returns at a falling edge
    task send_item(input logic [7:0] c, input bit last);
        if (burst_left == 0)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(negedge clk);
            burst_left = $urandom_range(1, 60);
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tdata  <= c;
        s_tlast  <= last;
        do
            @(posedge clk);
        while (!s_tready);
        sb.note_item(c, last);
        items_sent++;
        @(negedge clk);
    endtask

    task send_scalar(input logic [7:0] text[$]);
        foreach (text[i])
            send_item(text[i], 1'b0);
        send_item(8'($urandom_range(0, 255)), 1'b1);
    endtask

    task send_text(input string s);
        logic [7:0] text[$];
        for (int i = 0; i < s.len(); i++)
            text.push_back(s[i]);
        send_scalar(text);
    endtask

    function automatic void make_scalar(output logic [7:0] text[$]);
        string mix;
        string hexset;
        int kind;
        int n;
        int w;
        mix    = "0123456789+-.eEoxaAfFnNiI";
        hexset = "0123456789abcdefABCDEF";
        text   = {};
        kind   = $urandom_range(0, 9);
        case (kind)
            0, 1:
            begin
                n = $urandom_range(0, 2);
                if (n == 1) text.push_back(CH_PLUS);
                if (n == 2) text.push_back(CH_MINUS);
                repeat ($urandom_range(1, 6)) text.push_back(8'($urandom_range(8'h30, 8'h39)));
            end
            2:
            begin
                text = {CH_ZERO, CH_LO_O};
                repeat ($urandom_range(0, 5)) text.push_back(8'($urandom_range(8'h30, 8'h37)));
            end
            3:
            begin
                text = {CH_ZERO, CH_LO_X};
                repeat ($urandom_range(0, 5)) text.push_back(hexset[$urandom_range(0, 21)]);
            end
            4, 5:
            begin
                n = $urandom_range(0, 2);
                if (n == 1) text.push_back(CH_PLUS);
                if (n == 2) text.push_back(CH_MINUS);
                repeat ($urandom_range(0, 3)) text.push_back(8'($urandom_range(8'h30, 8'h39)));
                text.push_back(CH_DOT);
                repeat ($urandom_range(0, 3)) text.push_back(8'($urandom_range(8'h30, 8'h39)));
                if ($urandom_range(0, 1))
                begin
                    text.push_back($urandom_range(0, 1) ? CH_LO_E : CH_UP_E);
                    n = $urandom_range(0, 2);
                    if (n == 1) text.push_back(CH_PLUS);
                    if (n == 2) text.push_back(CH_MINUS);
                    repeat ($urandom_range(0, 2))
                        text.push_back(8'($urandom_range(8'h30, 8'h39)));
                end
            end
            6:
            begin
                n = $urandom_range(0, 3);
                if (n == 1) text.push_back(CH_PLUS);
                if (n == 2) text.push_back(CH_MINUS);
                w = $urandom_range(0, WORD_COUNT - 1);
                for (int k = 0; k < WORD_LEN; k++)
                    text.push_back(WORD_TABLE[w][k]);
            end
            7:
                repeat ($urandom_range(0, 6)) text.push_back(8'($urandom_range(0, 255)));
            8:
                repeat ($urandom_range(1, 7)) text.push_back(mix[$urandom_range(0, 24)]);
            default:
            begin
                n = $urandom_range(0, 2);
                if (n == 1) text.push_back(CH_PLUS);
                if (n == 2) text.push_back(CH_MINUS);
            end
        endcase
        // break a well-formed scalar now and then
        if (kind != 7 && text.size() > 0 && $urandom_range(0, 7) == 0)
        begin
            n = $urandom_range(0, text.size() - 1);
            text[n] = $urandom_range(0, 1) ? 8'($urandom_range(0, 255)) : mix[$urandom_range(0, 24)];
        end
        if (kind != 7 && $urandom_range(0, 11) == 0)
            text.push_back(mix[$urandom_range(0, 24)]);
    endfunction

    initial
    begin
        logic [7:0] text[$];
        clk        = 1'b0;
        rst_n      = 1'b0;
        s_tvalid   = 1'b0;
        s_tdata    = 8'h00;
        s_tlast    = 1'b0;
        m_tready   = 1'b0;
        items_sent = 0;
        burst_left = 0;
        cycles     = 0;
        ready_mode = 0;
        ready_hold = 0;
        sb = new();
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        send_text("");
        send_text("0");
        send_text("0o");
        send_text("0x");
        send_text("0o17");
        send_text("0o8");
        send_text("0xfF9A");
        send_text("-0x1");
        send_text("+");
        send_text("-");
        send_text("+12");
        send_text(".nan");
        send_text(".NaN");
        send_text(".NAN");
        send_text("-.nan");
        send_text("+.inf");
        send_text("-.Inf");
        send_text(".INF");
        send_text("1e5");
        send_text("1.5e-3");
        send_text(".5");
        send_text("5.");
        send_text(".");
        send_text("1.E+7");
        send_scalar({8'h00, 8'hFF});

        while (items_sent < ITEM_TARGET)
        begin
            make_scalar(text);
            send_scalar(text);
        end
        s_tvalid <= 1'b0;

        while (sb.pending_classes.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        sb.check_leftover();
        if (sb.errors == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
